// ===== hdl/vmc_pkg.sv =====
// Shared types, constants and helpers for the vehicle motion classifier.
// No dependencies; every other file of the block uses this package.
package vmc_pkg;

  localparam int SPEED_W    = 16;
  localparam int HEADING_W  = 15;
  localparam int HTHR_W     = 14;
  localparam int INTERVAL_W = 20;
  localparam int CLASS_W    = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Heading wrap limits in 1/64 degree units, sized for a heading difference.
  localparam logic signed [HEADING_W+1:0] HALF_TURN = 17'sd11520;
  localparam logic signed [HEADING_W+1:0] FULL_TURN = 17'sd23040;

  typedef enum logic [CLASS_W-1:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_STATIC  = 3'd1,
    CLS_MOVING  = 3'd2,
    CLS_ACCEL   = 3'd3,
    CLS_TURNING = 3'd4
  } class_t;

  typedef enum logic [2:0] {
    REG_SPEED_THR   = 3'd0,
    REG_HEADING_THR = 3'd1,
    REG_ACCEL_THR   = 3'd2,
    REG_INT_STATIC  = 3'd3,
    REG_INT_MOVING  = 3'd4,
    REG_INT_ACCEL   = 3'd5,
    REG_INT_TURNING = 3'd6
  } reg_idx_t;

  localparam logic [SPEED_W-1:0]    RST_SPEED_THR   = 16'd80;
  localparam logic [HTHR_W-1:0]     RST_HEADING_THR = 14'd1920;
  localparam logic [SPEED_W-1:0]    RST_ACCEL_THR   = 16'd160;
  localparam logic [INTERVAL_W-1:0] RST_INT_STATIC  = 20'd60000;
  localparam logic [INTERVAL_W-1:0] RST_INT_MOVING  = 20'd5000;
  localparam logic [INTERVAL_W-1:0] RST_INT_ACCEL   = 20'd2000;
  localparam logic [INTERVAL_W-1:0] RST_INT_TURNING = 20'd1000;

  typedef struct packed {
    logic [SPEED_W-1:0]    speed_thr;
    logic [HTHR_W-1:0]     heading_thr;
    logic [SPEED_W-1:0]    accel_thr;
    logic [INTERVAL_W-1:0] int_static;
    logic [INTERVAL_W-1:0] int_moving;
    logic [INTERVAL_W-1:0] int_accel;
    logic [INTERVAL_W-1:0] int_turning;
  } cfg_t;

  // Unknown and moving share the moving interval.
  function automatic logic [INTERVAL_W-1:0] interval_for(input class_t cls, input cfg_t cfg);
    logic [INTERVAL_W-1:0] iv;
    unique case (cls)
      CLS_TURNING: iv = cfg.int_turning;
      CLS_ACCEL:   iv = cfg.int_accel;
      CLS_STATIC:  iv = cfg.int_static;
      default:     iv = cfg.int_moving;
    endcase
    return iv;
  endfunction

endpackage

// ===== hdl/vmc_in_if.sv =====
// Input channel of the motion classifier: one GPS sample per item.
// Depends on vmc_pkg for field widths.
interface vmc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           fix_valid;
  logic                           speed_valid;
  logic [vmc_pkg::SPEED_W-1:0]    speed;
  logic                           heading_valid;
  logic [vmc_pkg::HEADING_W-1:0]  heading;

  modport source (output valid, fix_valid, speed_valid, speed, heading_valid, heading,
                  input ready);
  modport sink   (input valid, fix_valid, speed_valid, speed, heading_valid, heading,
                  output ready);
endinterface

// ===== hdl/vmc_out_if.sv =====
// Result channel of the motion classifier: class, interval and average speed.
// Depends on vmc_pkg for field widths.
interface vmc_out_if;
  logic                           valid;
  logic                           ready;
  logic [vmc_pkg::CLASS_W-1:0]    motion_class;
  logic [vmc_pkg::INTERVAL_W-1:0] report_interval;
  logic                           window_ready;
  logic [vmc_pkg::SPEED_W-1:0]    average_speed;

  modport source (output valid, motion_class, report_interval, window_ready, average_speed,
                  input ready);
  modport sink   (input valid, motion_class, report_interval, window_ready, average_speed,
                  output ready);
endinterface

// ===== hdl/vehicle_motion_classifier.sv =====
// Vehicle motion classifier, top level: config registers, core and average divider.
// Depends on vmc_pkg, vmc_in_if, vmc_out_if, vmc_cfg_regs, vmc_core, vmc_avg_div.
//
// Takes one GPS sample per cycle and returns one result per sample, in the cycle
// after the sample is accepted; a sample without a fix leaves the state alone and
// reports it as it is. Speed and heading windows of WINDOW entries are held in shift
// lines with a running speed sum, so each sample needs only the fixed taps at the
// window's end and the rate is set by the combinational path from the input through
// the sum update and the threshold compares into the result register. A new sample
// is taken in the same cycle that the previous result leaves, so samples flow back
// to back while the receiver keeps up; a result that waits holds the input off. The
// class stays unknown and the average speed reads 0 until WINDOW samples with a fix
// have arrived. Configuration must be written through the APB port while no sample
// is in flight; the block does not enforce it. No clearing pass follows reset.
module vehicle_motion_classifier #(
  parameter int WINDOW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  vmc_in_if.sink                            in_ch,
  vmc_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vmc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [vmc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [vmc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import vmc_pkg::*;

  localparam int SUM_W = SPEED_W + $clog2(WINDOW);

  cfg_t                  cfg;
  logic                  full;
  logic [SUM_W-1:0]      sum;
  logic [SPEED_W-1:0]    avg;

  vmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vmc_core #(.WINDOW(WINDOW)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_ch        (in_ch),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_class    (out_ch.motion_class),
    .out_interval (out_ch.report_interval),
    .out_full     (full),
    .out_sum      (sum)
  );

  vmc_avg_div #(.WINDOW(WINDOW)) u_div (
    .sum (sum),
    .avg (avg)
  );

  assign out_ch.window_ready  = full;
  assign out_ch.average_speed = full ? avg : '0;

endmodule

// ===== hdl/vmc_cfg_regs.sv =====
// APB-style configuration registers: thresholds and report intervals.
// Depends on vmc_pkg for the register map and the cfg_t bundle.
module vmc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vmc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [vmc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [vmc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output vmc_pkg::cfg_t                     cfg
);
  import vmc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_thr   <= RST_SPEED_THR;
      cfg_r.heading_thr <= RST_HEADING_THR;
      cfg_r.accel_thr   <= RST_ACCEL_THR;
      cfg_r.int_static  <= RST_INT_STATIC;
      cfg_r.int_moving  <= RST_INT_MOVING;
      cfg_r.int_accel   <= RST_INT_ACCEL;
      cfg_r.int_turning <= RST_INT_TURNING;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPEED_THR:   cfg_r.speed_thr   <= pwdata[SPEED_W-1:0];
        REG_HEADING_THR: cfg_r.heading_thr <= pwdata[HTHR_W-1:0];
        REG_ACCEL_THR:   cfg_r.accel_thr   <= pwdata[SPEED_W-1:0];
        REG_INT_STATIC:  cfg_r.int_static  <= pwdata[INTERVAL_W-1:0];
        REG_INT_MOVING:  cfg_r.int_moving  <= pwdata[INTERVAL_W-1:0];
        REG_INT_ACCEL:   cfg_r.int_accel   <= pwdata[INTERVAL_W-1:0];
        REG_INT_TURNING: cfg_r.int_turning <= pwdata[INTERVAL_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEED_THR:   prdata = CFG_DATA_W'(cfg_r.speed_thr);
      REG_HEADING_THR: prdata = CFG_DATA_W'(cfg_r.heading_thr);
      REG_ACCEL_THR:   prdata = CFG_DATA_W'(cfg_r.accel_thr);
      REG_INT_STATIC:  prdata = CFG_DATA_W'(cfg_r.int_static);
      REG_INT_MOVING:  prdata = CFG_DATA_W'(cfg_r.int_moving);
      REG_INT_ACCEL:   prdata = CFG_DATA_W'(cfg_r.int_accel);
      REG_INT_TURNING: prdata = CFG_DATA_W'(cfg_r.int_turning);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== hdl/vmc_core.sv =====
// Sample windows, running speed sum, classification and result register.
// Depends on vmc_pkg and vmc_in_if; speed and heading windows are shift lines.
module vmc_core #(
  parameter int WINDOW = 8
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  vmc_pkg::cfg_t                                  cfg,
  vmc_in_if.sink                                         in_ch,
  input  logic                                           out_ready,
  output logic                                           out_valid,
  output logic [vmc_pkg::CLASS_W-1:0]                    out_class,
  output logic [vmc_pkg::INTERVAL_W-1:0]                 out_interval,
  output logic                                           out_full,
  output logic [vmc_pkg::SPEED_W+$clog2(WINDOW)-1:0]     out_sum
);
  import vmc_pkg::*;

  localparam int SUM_W = SPEED_W + $clog2(WINDOW);
  localparam int IDX_W = $clog2(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
  localparam logic [SUM_W-1:0] WIN_L    = SUM_W'(WINDOW);

  // Entry 0 is the newest sample; entry WINDOW-1 leaves on the next write.
  logic [SPEED_W-1:0]   sw_r [WINDOW];
  logic [HEADING_W-1:0] hw_r [WINDOW];
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 full_r, full_nxt;
  logic [HEADING_W-1:0] held_r, held_nxt;
  class_t               cls_r, cls_nxt;

  logic                 out_valid_r;
  logic [CLASS_W-1:0]   out_class_r;
  logic [INTERVAL_W-1:0] out_interval_r;
  logic                 out_full_r;
  logic [SUM_W-1:0]     out_sum_r;

  logic                 accept, step;
  logic [SPEED_W-1:0]   spd;
  logic [HEADING_W-1:0] hdg;
  logic [SUM_W-1:0]     sum_new, bound;
  logic                 full_new;
  logic signed [HEADING_W+1:0] hd0, hd1, hd2;
  logic signed [SPEED_W:0]     sd;
  logic [HEADING_W+1:0] hmag;
  logic [SPEED_W:0]     smag;
  class_t               cls_new;

  assign in_ch.ready = !out_valid_r || out_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign step        = accept && in_ch.fix_valid;

  assign spd      = in_ch.speed_valid   ? in_ch.speed   : '0;
  assign hdg      = in_ch.heading_valid ? in_ch.heading : held_r;
  assign sum_new  = sum_r - SUM_W'(sw_r[WINDOW-1]) + SUM_W'(spd);
  assign full_new = full_r || (idx_r == IDX_LAST);
  assign bound    = SUM_W'(cfg.speed_thr) * WIN_L;

  // Oldest entry after this write sits one tap before the one leaving.
  assign hd0 = $signed({2'b00, hdg}) - $signed({2'b00, hw_r[WINDOW-2]});
  assign hd1 = (hd0 > HALF_TURN) ? hd0 - FULL_TURN : hd0;
  assign hd2 = (hd1 < -HALF_TURN) ? hd1 + FULL_TURN : hd1;
  assign hmag = hd2[HEADING_W+1] ? (HEADING_W+2)'(-hd2) : (HEADING_W+2)'(hd2);
  assign sd   = $signed({1'b0, spd}) - $signed({1'b0, sw_r[WINDOW-2]});
  assign smag = sd[SPEED_W] ? (SPEED_W+1)'(-sd) : (SPEED_W+1)'(sd);

  always_comb begin
    priority if ((sum_new > bound) && (hmag > (HEADING_W+2)'(cfg.heading_thr))) begin
      cls_new = CLS_TURNING;
    end else if (smag > (SPEED_W+1)'(cfg.accel_thr)) begin
      cls_new = CLS_ACCEL;
    end else if (sum_new >= bound) begin
      cls_new = CLS_MOVING;
    end else begin
      cls_new = CLS_STATIC;
    end
  end

  always_comb begin
    sum_nxt  = sum_r;
    idx_nxt  = idx_r;
    full_nxt = full_r;
    held_nxt = held_r;
    cls_nxt  = cls_r;
    if (step) begin
      sum_nxt  = sum_new;
      idx_nxt  = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
      full_nxt = full_new;
      held_nxt = hdg;
      if (full_new) begin
        cls_nxt = cls_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        sw_r[i] <= '0;
        hw_r[i] <= '0;
      end
      sum_r  <= '0;
      idx_r  <= '0;
      full_r <= 1'b0;
      held_r <= '0;
      cls_r  <= CLS_UNKNOWN;
    end else begin
      if (step) begin
        sw_r[0] <= spd;
        hw_r[0] <= hdg;
        for (int i = 1; i < WINDOW; i++) begin
          sw_r[i] <= sw_r[i-1];
          hw_r[i] <= hw_r[i-1];
        end
      end
      sum_r  <= sum_nxt;
      idx_r  <= idx_nxt;
      full_r <= full_nxt;
      held_r <= held_nxt;
      cls_r  <= cls_nxt;
    end
  end

  // Result register: every accepted item, fix or not, yields one result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_class_r    <= cls_nxt;
      out_interval_r <= interval_for(cls_nxt, cfg);
      out_full_r     <= full_nxt;
      out_sum_r      <= sum_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_class    = out_class_r;
  assign out_interval = out_interval_r;
  assign out_full     = out_full_r;
  assign out_sum      = out_sum_r;

endmodule

// ===== hdl/vmc_avg_div.sv =====
// Window average: speed sum divided by WINDOW through a reciprocal multiply.
// Depends on vmc_pkg for the speed width.
module vmc_avg_div #(
  parameter int WINDOW = 8
) (
  input  logic [vmc_pkg::SPEED_W+$clog2(WINDOW)-1:0] sum,
  output logic [vmc_pkg::SPEED_W-1:0]                avg
);
  import vmc_pkg::*;

  localparam int SUM_W = SPEED_W + $clog2(WINDOW);
  localparam int SHIFT = SUM_W + $clog2(WINDOW);
  localparam int MUL_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  // Rounded-up reciprocal; exact floor for every sum below 2**SUM_W.
  localparam longint unsigned RECIP =
    ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam logic [MUL_W-1:0] RECIP_L = MUL_W'(RECIP);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(sum) * PROD_W'(RECIP_L);
  assign avg  = prod[SHIFT+SPEED_W-1:SHIFT];

endmodule

// ===== test/vehicle_motion_classifier_tb.sv =====
// Testbench for vehicle_motion_classifier: GPS samples in, one motion report out per sample.
// Depends on vmc_pkg, vmc_in_if, vmc_out_if and the block itself; a tracker class
// predicts each report and checks it, plain tasks drive the sample and APB ports.
`timescale 1ns / 100ps

module vehicle_motion_classifier_tb;
  import vmc_pkg::*;

  localparam int WINDOW_LEN   = 8;
  localparam int UNUSED_REG   = 7;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 146;

  typedef struct packed {
    logic                 fix_valid;
    logic                 speed_valid;
    logic [SPEED_W-1:0]   speed;
    logic                 heading_valid;
    logic [HEADING_W-1:0] heading;
  } gps_sample_t;

  typedef struct packed {
    class_t                motion_class;
    logic [INTERVAL_W-1:0] report_interval;
    logic                  window_ready;
    logic [SPEED_W-1:0]    average_speed;
  } motion_report_t;

  // Tracks window state and thresholds, keeps the reports still owed by the block.
  class motion_tracker;
    localparam int DEPTH = WINDOW_LEN;
    localparam int HALF_TURN_UNITS = 11520;
    localparam int FULL_TURN_UNITS = 23040;

    cfg_t                 cfg;
    logic [SPEED_W-1:0]   speed_win [DEPTH];
    logic [HEADING_W-1:0] heading_win [DEPTH];
    int unsigned          speed_sum;
    int unsigned          wr_idx;
    bit                   full;
    logic [HEADING_W-1:0] last_heading;
    class_t               cls;
    motion_report_t       expected_reports [$];
    int unsigned          mismatches;

    function new();
      reset();
      mismatches = 0;
    endfunction

    function void reset();
      cfg.speed_thr   = RST_SPEED_THR;
      cfg.heading_thr = RST_HEADING_THR;
      cfg.accel_thr   = RST_ACCEL_THR;
      cfg.int_static  = RST_INT_STATIC;
      cfg.int_moving  = RST_INT_MOVING;
      cfg.int_accel   = RST_INT_ACCEL;
      cfg.int_turning = RST_INT_TURNING;
      foreach (speed_win[i]) begin
        speed_win[i]   = '0;
        heading_win[i] = '0;
      end
      speed_sum    = 0;
      wr_idx       = 0;
      full         = 1'b0;
      last_heading = '0;
      cls          = CLS_UNKNOWN;
    endfunction

    function void write_reg(int unsigned idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SPEED_THR:   cfg.speed_thr   = v[SPEED_W-1:0];
        REG_HEADING_THR: cfg.heading_thr = v[HTHR_W-1:0];
        REG_ACCEL_THR:   cfg.accel_thr   = v[SPEED_W-1:0];
        REG_INT_STATIC:  cfg.int_static  = v[INTERVAL_W-1:0];
        REG_INT_MOVING:  cfg.int_moving  = v[INTERVAL_W-1:0];
        REG_INT_ACCEL:   cfg.int_accel   = v[INTERVAL_W-1:0];
        REG_INT_TURNING: cfg.int_turning = v[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CFG_DATA_W-1:0] reg_value(int unsigned idx);
      logic [CFG_DATA_W-1:0] v;
      v = '0;
      case (idx)
        REG_SPEED_THR:   v[SPEED_W-1:0]    = cfg.speed_thr;
        REG_HEADING_THR: v[HTHR_W-1:0]     = cfg.heading_thr;
        REG_ACCEL_THR:   v[SPEED_W-1:0]    = cfg.accel_thr;
        REG_INT_STATIC:  v[INTERVAL_W-1:0] = cfg.int_static;
        REG_INT_MOVING:  v[INTERVAL_W-1:0] = cfg.int_moving;
        REG_INT_ACCEL:   v[INTERVAL_W-1:0] = cfg.int_accel;
        REG_INT_TURNING: v[INTERVAL_W-1:0] = cfg.int_turning;
        default: ;
      endcase
      return v;
    endfunction

    function logic [INTERVAL_W-1:0] interval_of(class_t c);
      case (c)
        CLS_TURNING: return cfg.int_turning;
        CLS_ACCEL:   return cfg.int_accel;
        CLS_STATIC:  return cfg.int_static;
        default:     return cfg.int_moving;
      endcase
    endfunction

    function class_t classify();
      int unsigned newest, oldest, bound, hmag, smag;
      int hd, sd;
      newest = (wr_idx + DEPTH - 1) % DEPTH;
      oldest = wr_idx % DEPTH;
      bound  = cfg.speed_thr * DEPTH;
      hd = int'(heading_win[newest]) - int'(heading_win[oldest]);
      sd = int'(speed_win[newest]) - int'(speed_win[oldest]);
      // single wrap correction, also for headings past a full turn
      if (hd > HALF_TURN_UNITS) hd -= FULL_TURN_UNITS;
      if (hd < -HALF_TURN_UNITS) hd += FULL_TURN_UNITS;
      hmag = (hd < 0) ? -hd : hd;
      smag = (sd < 0) ? -sd : sd;
      if (speed_sum > bound && hmag > cfg.heading_thr) return CLS_TURNING;
      if (smag > cfg.accel_thr) return CLS_ACCEL;
      if (speed_sum >= bound) return CLS_MOVING;
      return CLS_STATIC;
    endfunction

    function void record_sample(gps_sample_t s);
      logic [SPEED_W-1:0]   spd;
      logic [HEADING_W-1:0] hdg;
      int unsigned          idx;
      motion_report_t       r;
      if (s.fix_valid) begin
        spd = s.speed_valid ? s.speed : '0;
        hdg = s.heading_valid ? s.heading : last_heading;
        idx = wr_idx % DEPTH;
        speed_sum = speed_sum - speed_win[idx] + spd;
        speed_win[idx]   = spd;
        heading_win[idx] = hdg;
        wr_idx = (idx + 1) % DEPTH;
        if (wr_idx == 0) full = 1'b1;
        if (full) cls = classify();
        last_heading = hdg;
      end
      r.motion_class    = cls;
      r.report_interval = interval_of(cls);
      r.window_ready    = full;
      r.average_speed   = full ? SPEED_W'(speed_sum / DEPTH) : '0;
      expected_reports.push_back(r);
    endfunction

    function void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_report(motion_report_t got);
      motion_report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: report with nothing pending (class %0d, interval %0d)",
                   got.motion_class, got.report_interval);
        return;
      end
      want = expected_reports.pop_front();
      if (got.motion_class !== want.motion_class)
        report_mismatch("motion_class", want.motion_class, got.motion_class);
      if (got.report_interval !== want.report_interval)
        report_mismatch("report_interval", want.report_interval, got.report_interval);
      if (got.window_ready !== want.window_ready)
        report_mismatch("window_ready", want.window_ready, got.window_ready);
      if (got.average_speed !== want.average_speed)
        report_mismatch("average_speed", want.average_speed, got.average_speed);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  vmc_in_if  in_ch ();
  vmc_out_if out_ch ();

  motion_tracker tracker = new();

  int unsigned accepted_inputs = 0;
  int unsigned quiet_cycles = 0;
  int          burst_left = 0;

  vehicle_motion_classifier #(.WINDOW(WINDOW_LEN)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : watch_inputs
    gps_sample_t s;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      s.fix_valid     = in_ch.fix_valid;
      s.speed_valid   = in_ch.speed_valid;
      s.speed         = in_ch.speed;
      s.heading_valid = in_ch.heading_valid;
      s.heading       = in_ch.heading;
      tracker.record_sample(s);
      accepted_inputs++;
    end
  end

  always @(posedge clk) begin : watch_reports
    motion_report_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.motion_class    = class_t'(out_ch.motion_class);
      r.report_interval = out_ch.report_interval;
      r.window_ready    = out_ch.window_ready;
      r.average_speed   = out_ch.average_speed;
      tracker.check_report(r);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off to fill the block.
  initial begin : receiver
    int  seg, mode;
    bit  held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && accepted_inputs >= HOLD_AT) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      mode = int'($urandom_range(0, 2));
      seg  = int'($urandom_range(10, 60));
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic offer(gps_sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 40));
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.fix_valid     <= s.fix_valid;
    in_ch.speed_valid   <= s.speed_valid;
    in_ch.speed         <= s.speed;
    in_ch.heading_valid <= s.heading_valid;
    in_ch.heading       <= s.heading;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic offer_fields(bit fix, bit sv, int spd, bit hv, int hdg);
    gps_sample_t s;
    s.fix_valid     = fix;
    s.speed_valid   = sv;
    s.speed         = SPEED_W'(spd);
    s.heading_valid = hv;
    s.heading       = HEADING_W'(hdg);
    offer(s);
  endtask

  // Drop valid, wait for every owed report, then let the pipeline go quiet.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(int unsigned idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [CFG_DATA_W-1:0] got;
    for (int r = REG_SPEED_THR; r <= REG_INT_TURNING; r++) begin
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CFG_ADDR_W'(r * 4);
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      if (got !== tracker.reg_value(r))
        tracker.report_mismatch("register read", tracker.reg_value(r), got);
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // Mostly coherent drives (steady, ramps, turns) with random gaps in the fix and
  // valid flags, plus some raw noise samples.
  task automatic random_phase(int n);
    int          done, seg_len, thr, base, step, hbase, hstep, spd, hdg;
    gps_sample_t s;
    done = 0;
    thr  = int'(tracker.cfg.speed_thr);
    while (done < n) begin
      seg_len = int'($urandom_range(4, 24));
      case ($urandom_range(0, 4))
        0: begin base = int'($urandom_range(0, thr)); step = 0; end
        1: begin
          base = thr + int'($urandom_range(0, 64)) - 32;
          step = int'($urandom_range(0, 2)) - 1;
        end
        2: begin
          base = int'($urandom_range(0, 65535));
          step = int'($urandom_range(0, 400)) - 200;
        end
        3: begin
          base = ($urandom_range(0, 1) == 0) ? 0 : 65535;
          step = int'($urandom_range(0, 4000)) - 2000;
        end
        default: begin
          base = int'($urandom_range(0, 3 * thr + 100));
          step = int'($urandom_range(0, 100)) - 50;
        end
      endcase
      hbase = int'($urandom_range(0, 23039));
      hstep = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 6000)) - 3000;
      for (int k = 0; k < seg_len && done < n; k++) begin
        spd = base + k * step;
        if (spd < 0) spd = 0;
        if (spd > 65535) spd = 65535;
        hdg = (hbase + k * hstep) % 23040;
        if (hdg < 0) hdg += 23040;
        s.fix_valid     = ($urandom_range(0, 11) != 0);
        s.speed_valid   = ($urandom_range(0, 11) != 0);
        s.speed         = SPEED_W'(spd);
        s.heading_valid = ($urandom_range(0, 11) != 0);
        s.heading       = HEADING_W'(hdg);
        if ($urandom_range(0, 19) == 0) begin
          s.fix_valid     = 1'($urandom_range(0, 1));
          s.speed_valid   = 1'($urandom_range(0, 1));
          s.speed         = SPEED_W'($urandom_range(0, 65535));
          s.heading_valid = 1'($urandom_range(0, 1));
          s.heading       = HEADING_W'($urandom_range(0, 32767));
        end
        offer(s);
        done++;
      end
    end
  endtask

  initial begin : main
    logic [CFG_DATA_W-1:0] vals [UNUSED_REG];
    in_ch.valid         = 1'b0;
    in_ch.fix_valid     = 1'b0;
    in_ch.speed_valid   = 1'b0;
    in_ch.speed         = '0;
    in_ch.heading_valid = 1'b0;
    in_ch.heading       = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_regs();

    // Reset thresholds: bound on the sum is 640.
    offer_fields(0, 1, 65535, 1, 23039);   // no fix, nothing moves
    offer_fields(1, 1, 0, 1, 0);
    offer_fields(1, 0, 65535, 1, 23039);   // speed flagged invalid
    offer_fields(1, 1, 65535, 0, 12345);   // heading held
    offer_fields(1, 1, 65535, 1, 32767);   // heading past a full turn
    offer_fields(1, 1, 65535, 1, 16384);
    offer_fields(1, 1, 65535, 1, 0);
    offer_fields(1, 1, 65535, 1, 11520);
    offer_fields(1, 1, 65535, 1, 23000);   // window fills here
    offer_fields(0, 0, 0, 0, 0);
    repeat (8) offer_fields(1, 1, 80, 1, 23000);  // sum equals bound
    offer_fields(1, 1, 81, 1, 100);        // wraps to a small heading change
    offer_fields(1, 1, 81, 1, 5000);       // turning across north
    offer_fields(1, 1, 0, 1, 5000);
    offer_fields(1, 1, 400, 1, 5000);
    offer_fields(1, 0, 1234, 0, 777);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: foreach (vals[i]) vals[i] = '0;
        1: begin
          vals[REG_SPEED_THR]   = 65535;
          vals[REG_HEADING_THR] = 11520;
          vals[REG_ACCEL_THR]   = 65535;
          vals[REG_INT_STATIC]  = 1048575;
          vals[REG_INT_MOVING]  = 1048575;
          vals[REG_INT_ACCEL]   = 1048575;
          vals[REG_INT_TURNING] = 1048575;
        end
        default: begin
          vals[REG_SPEED_THR]   = $urandom_range(0, 1500);
          vals[REG_HEADING_THR] = $urandom_range(0, 11520);
          vals[REG_ACCEL_THR]   = $urandom_range(0, 1500);
          vals[REG_INT_STATIC]  = $urandom_range(0, 1048575);
          vals[REG_INT_MOVING]  = $urandom_range(0, 1048575);
          vals[REG_INT_ACCEL]   = $urandom_range(0, 1048575);
          vals[REG_INT_TURNING] = $urandom_range(0, 1048575);
        end
      endcase
      for (int r = REG_SPEED_THR; r <= REG_INT_TURNING; r++) cfg_write(r, vals[r]);
      if (phase == 2) cfg_write(UNUSED_REG, 32'h0000_1234);
      check_regs();
      random_phase(PHASE_ITEMS);
      settle();
    end

    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
